// ===== hdl/flagged_integer_alu_top_assert.svh =====
// assertion macros used by the checker file fia_checker.sv
`ifndef FLAGGED_INTEGER_ALU_TOP_ASSERT_SVH
`define FLAGGED_INTEGER_ALU_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define FIA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fia assertion failed");

// next-cycle implication
`define FIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fia assertion failed");

`endif

// ===== hdl/fia_pkg.sv =====
`default_nettype none

package fia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int ACT_W      = 3;

    typedef enum logic [ACT_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_AND = 3'd4,
        OP_OR  = 3'd5,
        OP_SHL = 3'd6,
        OP_SHR = 3'd7
    } t_op;

endpackage

`default_nettype wire

// ===== hdl/flagged_integer_alu_top.sv =====
// integer alu with status flags, processed one bit per cycle
//
// input channel : i_in_valid / o_in_ready carry one beat of i_action,
//                 i_operand_a, i_operand_b
// output channel: o_out_valid / i_out_ready carry one beat of o_result and
//                 the zero, greater_zero, overflow and divide_by_zero flags
//
// every operation but a divide by zero runs through the same serial
// datapath in 32 steps, one bit (add, sub, logic, shifts), one multiplier
// bit (shift-add multiply) or one quotient bit (restoring divide) per cycle,
// then updates the result register and flags in the done state. a divide by
// zero skips the datapath and goes straight to the done state. one item is
// in work at a time: no new item is taken until the last one has committed.
// the finished beat sits in an output register, so the next item is taken
// while it waits. if the receiver stalls, the next item finishes its serial
// steps and then waits before committing until the output register is free.
// reset clears the result register, its flags and the control state.
`default_nettype none

module flagged_integer_alu_top
    import fia_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [ACT_W-1:0]      i_action,
    input  wire logic [DATA_WIDTH-1:0] i_operand_a,
    input  wire logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [DATA_WIDTH-1:0]      o_result,
    output logic                       o_zero,
    output logic                       o_greater_zero,
    output logic                       o_overflow,
    output logic                       o_divide_by_zero
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    t_op                   r_op;
    logic                  r_dz;
    logic                  r_cy;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_res;

    // architectural state
    logic [DATA_WIDTH-1:0] r_hold;
    logic                  r_zf;
    logic                  r_pf;
    logic                  r_cf;

    // output beat register
    logic                  r_ovalid;
    logic [DATA_WIDTH-1:0] r_o_result;
    logic                  r_o_zf;
    logic                  r_o_pf;
    logic                  r_o_cf;
    logic                  r_o_df;

    logic [DATA_WIDTH-1:0] n_a;
    logic [DATA_WIDTH-1:0] n_b;
    logic [DATA_WIDTH-1:0] n_acc;
    logic [DATA_WIDTH-1:0] n_res;
    logic                  n_cy;
    logic [DATA_WIDTH-1:0] n_hold;
    logic                  n_zf;
    logic                  n_pf;
    logic                  n_cf;
    logic                  n_df;

    logic                  s_accept;
    logic                  s_commit;
    logic                  s_bx;
    logic                  s_bit;
    logic [DATA_WIDTH:0]   s_mul;
    logic [DATA_WIDTH:0]   s_rem;
    logic [DATA_WIDTH-1:0] s_diff;
    logic                  s_ge;

    assign o_in_ready = (r_state == S_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_commit   = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    // one serial step of the datapath
    always_comb begin
        s_bx   = (r_op == OP_SUB) ? ~r_b[0] : r_b[0];
        s_mul  = {1'b0, r_acc} + (r_b[0] ? {1'b0, r_a} : '0);
        s_rem  = {r_acc, r_a[DATA_WIDTH-1]};
        s_ge   = (s_rem >= {1'b0, r_b});
        // only used when the partial remainder covers the divisor
        s_diff = s_rem[DATA_WIDTH-1:0] - r_b;
        n_a    = {1'b0, r_a[DATA_WIDTH-1:1]};
        n_b    = {1'b0, r_b[DATA_WIDTH-1:1]};
        n_acc  = r_acc;
        n_cy   = r_cy;
        s_bit  = 1'b0;
        unique case (r_op)
            OP_ADD, OP_SUB: begin
                s_bit = r_a[0] ^ s_bx ^ r_cy;
                n_cy  = (r_a[0] & s_bx) | (r_cy & (r_a[0] ^ s_bx));
            end
            OP_MUL: begin
                n_a   = r_a;
                n_acc = s_mul[DATA_WIDTH:1];
                s_bit = s_mul[0];
            end
            OP_DIV: begin
                n_a   = {r_a[DATA_WIDTH-2:0], 1'b0};
                n_b   = r_b;
                n_acc = s_ge ? s_diff : s_rem[DATA_WIDTH-1:0];
                s_bit = s_ge;
            end
            OP_AND: s_bit = r_a[0] & r_b[0];
            OP_OR:  s_bit = r_a[0] | r_b[0];
            OP_SHL: begin
                // carry holds the previous operand bit, ends as the top bit
                s_bit = r_cy;
                n_cy  = r_a[0];
            end
            OP_SHR: s_bit = r_a[1];
            default: s_bit = 1'b0;
        endcase
        // quotient fills from the bottom, everything else from the top
        if (r_op == OP_DIV) begin
            n_res = {r_res[DATA_WIDTH-2:0], s_bit};
        end else begin
            n_res = {s_bit, r_res[DATA_WIDTH-1:1]};
        end
    end

    // result register and flag update at the end of an item
    always_comb begin
        n_hold = r_hold;
        n_zf   = r_zf;
        n_pf   = r_pf;
        n_cf   = r_cf;
        n_df   = 1'b1;
        if (!r_dz) begin
            n_hold = r_res;
            n_zf   = (r_res == '0);
            n_pf   = (r_res != '0);
            n_df   = 1'b0;
            unique case (r_op)
                OP_ADD:  n_cf = r_cy;
                OP_SUB:  n_cf = ~r_cy;
                OP_SHL:  n_cf = r_cy;
                OP_MUL:  n_cf = r_cf;
                default: n_cf = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_dz     <= 1'b0;
            r_hold   <= '0;
            r_zf     <= 1'b0;
            r_pf     <= 1'b0;
            r_cf     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_cnt <= '0;
                        if (t_op'(i_action) == OP_DIV && i_operand_b == '0) begin
                            r_dz    <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_dz    <= 1'b0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (s_commit) begin
                        r_hold  <= n_hold;
                        r_zf    <= n_zf;
                        r_pf    <= n_pf;
                        r_cf    <= n_cf;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (s_commit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath and output beat payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= t_op'(i_action);
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
            r_acc <= '0;
            r_res <= '0;
            r_cy  <= (t_op'(i_action) == OP_SUB);
        end else if (r_state == S_RUN) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_acc <= n_acc;
            r_res <= n_res;
            r_cy  <= n_cy;
        end
        if (s_commit) begin
            r_o_result <= n_hold;
            r_o_zf     <= n_zf;
            r_o_pf     <= n_pf;
            r_o_cf     <= n_cf;
            r_o_df     <= n_df;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_result         = r_o_result;
    assign o_zero           = r_o_zf;
    assign o_greater_zero   = r_o_pf;
    assign o_overflow       = r_o_cf;
    assign o_divide_by_zero = r_o_df;

endmodule

`default_nettype wire

// ===== hdl/fia_checker.sv =====
`include "flagged_integer_alu_top_assert.svh"
`default_nettype none

module fia_checker
    import fia_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [DATA_WIDTH-1:0] o_result,
    input wire logic                  o_zero,
    input wire logic                  o_greater_zero,
    input wire logic                  o_overflow,
    input wire logic                  o_divide_by_zero
);

    // after any committed operation but a divide by zero exactly one of zero and nonzero is set
    `FIA_ASSERT_IMPLY(a_zero_excl, i_clk, i_rst_n, o_out_valid && !o_divide_by_zero, o_zero != o_greater_zero)

    // zero flag agrees with the result it describes
    `FIA_ASSERT_IMPLY(a_zero_result, i_clk, i_rst_n, o_out_valid && o_zero, o_result == '0)

    // one item at a time: the block is busy right after taking a beat
    `FIA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled output beat holds
    `FIA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result) && $stable(o_overflow))

endmodule

bind flagged_integer_alu_top fia_checker u_fia_checker (.*);

`default_nettype wire
